### rtl/lkvc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lkvc_pkg
// shared constants and request/response types of the lru key-value cache
// ----------------------------------------------------------------------------
package lkvc_pkg;

    localparam int MAX_ENTRIES = 16;
    localparam int CAP_W       = 5;
    localparam int DATA_W      = 32;
    localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
    localparam int RANK_W      = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CMP_W       = (CNT_W > CAP_W) ? CNT_W : CAP_W;

    localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

    localparam logic FUNC_GET = 1'b0;
    localparam logic FUNC_PUT = 1'b1;

    typedef struct packed {
        logic                     func;
        logic signed [DATA_W-1:0] lookup_key;
        logic signed [DATA_W-1:0] write_value;
    } req_t;

    typedef struct packed {
        logic                     hit;
        logic signed [DATA_W-1:0] read_value;
        logic                     evicted;
        logic signed [DATA_W-1:0] evicted_key;
    } rsp_t;

endpackage

### rtl/lkvc_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lkvc_core
// entry storage, parallel key match, lru selection and recency update
// ----------------------------------------------------------------------------
module lkvc_core
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         clear,
    input  logic [lkvc_pkg::CAP_W-1:0]   capacity,
    input  logic                         update,
    input  lkvc_pkg::req_t               req,
    output lkvc_pkg::rsp_t               rsp
);

    localparam int N = lkvc_pkg::MAX_ENTRIES;

    logic [N-1:0]                        entry_valid_reg;
    logic signed [lkvc_pkg::DATA_W-1:0]  entry_key_reg   [N];
    logic signed [lkvc_pkg::DATA_W-1:0]  entry_value_reg [N];
    logic [lkvc_pkg::RANK_W-1:0]         rank_reg        [N];

    logic [N-1:0]                        match;
    logic [N-1:0]                        found_oh;
    logic [N-1:0]                        free_oh;
    logic [N-1:0]                        lru_oh;
    logic [N-1:0]                        slot_oh;
    logic                                found;
    logic                                insert;
    logic                                evict;
    logic                                full;
    logic [lkvc_pkg::CNT_W-1:0]          count;
    logic [lkvc_pkg::CNT_W-1:0]          count_m1;
    logic [lkvc_pkg::CMP_W-1:0]          eff_cap;
    logic [lkvc_pkg::RANK_W-1:0]         slot_rank;
    logic signed [lkvc_pkg::DATA_W-1:0]  found_value;
    logic signed [lkvc_pkg::DATA_W-1:0]  lru_key;

    // clamp capacity into 1..N
    always_comb
    begin
        if (capacity == '0)
            eff_cap = lkvc_pkg::CMP_W'(1);
        else if (lkvc_pkg::CMP_W'(capacity) > lkvc_pkg::CMP_W'(N))
            eff_cap = lkvc_pkg::CMP_W'(N);
        else
            eff_cap = lkvc_pkg::CMP_W'(capacity);
    end

    always_comb
    begin
        count = '0;
        for (int i = 0; i < N; i++)
        begin
            match[i] = entry_valid_reg[i] && (entry_key_reg[i] == req.lookup_key);
            count    = count + lkvc_pkg::CNT_W'(entry_valid_reg[i]);
        end
    end

    assign count_m1 = count - lkvc_pkg::CNT_W'(1);
    assign full     = lkvc_pkg::CMP_W'(count) >= eff_cap;

    // lowest matching slot and lowest free slot, one-hot
    always_comb
    begin
        logic seen_match;
        logic seen_free;
        seen_match = 1'b0;
        seen_free  = 1'b0;
        for (int i = 0; i < N; i++)
        begin
            found_oh[i] = match[i] && !seen_match;
            free_oh[i]  = !entry_valid_reg[i] && !seen_free;
            seen_match  = seen_match || match[i];
            seen_free   = seen_free || !entry_valid_reg[i];
        end
    end

    // ranks of valid entries are distinct, the oldest holds count-1
    always_comb
    begin
        for (int i = 0; i < N; i++)
            lru_oh[i] = entry_valid_reg[i] &&
                        (rank_reg[i] == count_m1[lkvc_pkg::RANK_W-1:0]);
    end

    always_comb
    begin
        slot_rank   = '0;
        found_value = '0;
        lru_key     = '0;
        for (int i = 0; i < N; i++)
        begin
            slot_rank   = slot_rank   | (rank_reg[i] & {lkvc_pkg::RANK_W{found_oh[i]}});
            found_value = found_value |
                          (entry_value_reg[i] & {lkvc_pkg::DATA_W{found_oh[i]}});
            lru_key     = lru_key | (entry_key_reg[i] & {lkvc_pkg::DATA_W{lru_oh[i]}});
        end
    end

    assign found  = |match;
    assign insert = (req.func == lkvc_pkg::FUNC_PUT) && !found;
    assign evict  = insert && full;

    always_comb
    begin
        if (found)
            slot_oh = found_oh;
        else if (evict)
            slot_oh = lru_oh;
        else
            slot_oh = free_oh;
    end

    always_comb
    begin
        rsp.hit     = found;
        rsp.evicted = evict;
        if (req.func == lkvc_pkg::FUNC_PUT)
            rsp.read_value = '0;
        else if (found)
            rsp.read_value = found_value;
        else
            rsp.read_value = '1;
        rsp.evicted_key = evict ? lru_key : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_valid_reg <= '0;
        end
        else if (clear)
        begin
            entry_valid_reg <= '0;
        end
        else if (update && insert)
        begin
            entry_valid_reg <= entry_valid_reg | slot_oh;
        end
    end

    always_ff @(posedge clk)
    begin
        if (update && (found || insert))
        begin
            for (int i = 0; i < N; i++)
            begin
                if (slot_oh[i])
                begin
                    rank_reg[i] <= '0;
                    if (req.func == lkvc_pkg::FUNC_PUT)
                        entry_value_reg[i] <= req.write_value;
                    if (insert)
                        entry_key_reg[i] <= req.lookup_key;
                end
                else if (entry_valid_reg[i] && (insert || rank_reg[i] < slot_rank))
                begin
                    rank_reg[i] <= rank_reg[i] + lkvc_pkg::RANK_W'(1);
                end
            end
        end
    end

endmodule

### rtl/lru_key_value_cache.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lru_key_value_cache
// fully associative key-value cache with least-recently-used replacement
// ----------------------------------------------------------------------------
// a request is held in the request register and moves into the result register once that is free
// throughput: one request per cycle while the output is not stalled by out_ready; the match and
//   recency update across all entries lie between the request and result registers
// reset: all entries invalid, capacity 16; a capacity write also empties the cache
module lru_key_value_cache
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_write_en,
    input  logic [lkvc_pkg::CAP_W-1:0]          cfg_write_data,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic                                func,
    input  logic signed [lkvc_pkg::DATA_W-1:0]  lookup_key,
    input  logic signed [lkvc_pkg::DATA_W-1:0]  write_value,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic                                hit,
    output logic signed [lkvc_pkg::DATA_W-1:0]  read_value,
    output logic                                evicted,
    output logic signed [lkvc_pkg::DATA_W-1:0]  evicted_key
);

    logic [lkvc_pkg::CAP_W-1:0] active_capacity_reg;
    logic                       req_valid_reg;
    lkvc_pkg::req_t             req_reg;
    logic                       out_valid_reg;
    lkvc_pkg::rsp_t             rsp_reg;
    lkvc_pkg::rsp_t             rsp;
    logic                       advance;

    // request moves into the result register and updates the entries
    assign advance  = req_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !req_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            active_capacity_reg <= lkvc_pkg::CAP_RESET;
        else if (cfg_write_en)
            active_capacity_reg <= cfg_write_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            req_valid_reg <= 1'b0;
        else if (in_ready)
            req_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            req_reg.func        <= func;
            req_reg.lookup_key  <= lookup_key;
            req_reg.write_value <= write_value;
        end
    end

    lkvc_core u_core
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .clear    (cfg_write_en),
        .capacity (active_capacity_reg),
        .update   (advance),
        .req      (req_reg),
        .rsp      (rsp)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            rsp_reg <= rsp;
    end

    assign out_valid   = out_valid_reg;
    assign hit         = rsp_reg.hit;
    assign read_value  = rsp_reg.read_value;
    assign evicted     = rsp_reg.evicted;
    assign evicted_key = rsp_reg.evicted_key;

endmodule
